@@ rtl/tlv_stream_parser_crc_check_unit_defines.svh @@
// assertion macros shared by the tlv parser rtl
`ifndef TLV_STREAM_PARSER_CRC_CHECK_UNIT_DEFINES_SVH
`define TLV_STREAM_PARSER_CRC_CHECK_UNIT_DEFINES_SVH

// clock and reset given explicitly
`define TLVCRC_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tlvcrc assertion failed");

// default clock and reset of the block
`define TLVCRC_ASSERT(label, prop) \
  `TLVCRC_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

@@ rtl/tlvcrc_pkg.sv @@
// types, constants and crc helper for the tlv parser
package tlvcrc_pkg;

  localparam int unsigned MaxRecordsDef = 16;
  localparam logic [31:0] CrcPoly       = 32'hEDB8_8320;

  typedef enum logic [1:0] {
    PhType,
    PhLenHi,
    PhLenLo,
    PhValue
  } tlvcrc_phase_e;

  typedef enum logic [1:0] {
    StOk,
    StTooMany,
    StTruncated,
    StMismatch
  } tlvcrc_status_e;

  // reflected crc-32, one byte, with inversion on entry and exit
  function automatic logic [31:0] crc_add_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = ~crc;
    c[7:0] = c[7:0] ^ b;
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'h0);
    end
    return ~c;
  endfunction

endpackage

@@ rtl/tlvcrc_if.sv @@
// valid/ready channels for raw message bytes and parsed results
interface tlvcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface tlvcrc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  value_byte;
  logic        value_valid;
  logic [7:0]  record_type;
  logic [3:0]  record_index;
  logic [15:0] record_length;
  logic        record_done;
  logic        message_done;
  logic [1:0]  status;
  logic [4:0]  record_count;

  modport source (
    output valid, output value_byte, output value_valid, output record_type,
    output record_index, output record_length, output record_done,
    output message_done, output status, output record_count, input ready
  );
  modport sink (
    input valid, input value_byte, input value_valid, input record_type,
    input record_index, input record_length, input record_done,
    input message_done, input status, input record_count, output ready
  );
endinterface

@@ rtl/tlv_stream_parser_crc_check_unit.sv @@
// tlv stream parser with running crc-32 and checksum record check
//
// in_i carries one message word per handshake: a raw byte and an end flag.
// out_o returns exactly one result word per input word, in order, with the
// value byte (if any), the record type, index and length, record and message
// done flags, status and the count of completed records.
// cfg_we_i/cfg_data_i write the checksum record type; write only while idle.
// result valid follows in the cycle after the input handshake. throughput: one
// word per cycle while out_o.ready is high; the parser state and the one-byte
// crc update are combinational, which is what sets this rate.
// the result register decouples the sides: a new word is taken in the same
// cycle the pending result is taken, and while out_o.ready is low the result
// holds and in_i.ready drops only once the result register is occupied.
// reset clears the parse state, crc, counters and the checksum type to zero.
// after an error the rest of the message is consumed without value output;
// the end-of-message word reports the final status and returns the parser
// to its start state for the next message.
`include "tlv_stream_parser_crc_check_unit_defines.svh"

module tlv_stream_parser_crc_check_unit #(
  parameter int unsigned MaxRecords = tlvcrc_pkg::MaxRecordsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  tlvcrc_in_if.sink         in_i,
  tlvcrc_out_if.source      out_o
);
  import tlvcrc_pkg::*;

  localparam int unsigned CntW = $clog2(MaxRecords + 1);
  localparam int unsigned ExtW = (CntW > 5) ? CntW : 5;

  logic [7:0]     cfg_type_q;
  tlvcrc_phase_e  phase_q, phase_d;
  tlvcrc_status_e err_q, err_d;
  logic [7:0]     type_q, type_d;
  logic [15:0]    len_q, len_d;
  logic [15:0]    left_q, left_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]    crc_q, crc_d;
  logic [31:0]    snap_q, snap_d;
  logic           cmp_q, cmp_d;

  logic           in_fire;
  logic           val_d, done_d;
  logic [15:0]    pos;
  logic [7:0]     want;
  logic           is_chk;
  logic           fin;
  logic [ExtW-1:0] cnt_old_ext, cnt_new_ext;

  logic           ovalid_q;
  logic [7:0]     o_byte_q, o_type_q;
  logic           o_val_q, o_done_q, o_msg_q;
  logic [3:0]     o_idx_q;
  logic [15:0]    o_len_q;
  logic [1:0]     o_stat_q;
  logic [4:0]     o_cnt_q;

  assign in_i.ready = !ovalid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign pos    = len_q - left_q;
  assign want   = snap_q[{2'd3 - pos[1:0], 3'b000} +: 8];
  assign is_chk = (type_q == cfg_type_q);

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    type_d  = type_q;
    len_d   = len_q;
    left_d  = left_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    snap_d  = snap_q;
    cmp_d   = cmp_q;
    val_d   = 1'b0;
    done_d  = 1'b0;
    fin     = 1'b0;
    if (err_q == StOk) begin
      case (phase_q)
        PhType: begin
          if (cnt_q >= CntW'(MaxRecords)) begin
            err_d = StTooMany;
          end else begin
            type_d  = in_i.data_byte;
            len_d   = 16'h0;
            phase_d = PhLenHi;
          end
        end
        PhLenHi: begin
          len_d   = {in_i.data_byte, 8'h00};
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          len_d  = {len_q[15:8], in_i.data_byte};
          left_d = len_d;
          snap_d = crc_q;
          cmp_d  = 1'b1;
          if (len_d == 16'h0) begin
            fin = 1'b1;
          end else begin
            phase_d = PhValue;
          end
        end
        PhValue: begin
          val_d = 1'b1;
          if (is_chk && pos < 16'd4 && want != in_i.data_byte) begin
            cmp_d = 1'b0;
          end
          crc_d  = crc_add_byte(crc_q, in_i.data_byte);
          left_d = left_q - 16'd1;
          fin    = (left_d == 16'h0);
        end
        default: ;
      endcase
      // closing a record: checksum record must be long enough and match
      if (fin) begin
        if (is_chk && (len_d < 16'd4 || !cmp_d)) begin
          err_d = StMismatch;
        end else begin
          cnt_d   = cnt_q + CntW'(1);
          phase_d = PhType;
          done_d  = 1'b1;
        end
      end
      if (in_i.end_of_message && err_d == StOk && phase_d != PhType) begin
        err_d = StTruncated;
      end
    end
  end

  assign cnt_old_ext = ExtW'(cnt_q);
  assign cnt_new_ext = ExtW'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_type_q <= 8'h0;
    end else if (cfg_we_i) begin
      cfg_type_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhType;
      err_q   <= StOk;
      type_q  <= 8'h0;
      len_q   <= 16'h0;
      left_q  <= 16'h0;
      cnt_q   <= '0;
      crc_q   <= 32'h0;
      snap_q  <= 32'h0;
      cmp_q   <= 1'b1;
    end else if (in_fire) begin
      if (in_i.end_of_message) begin
        phase_q <= PhType;
        err_q   <= StOk;
        type_q  <= 8'h0;
        len_q   <= 16'h0;
        left_q  <= 16'h0;
        cnt_q   <= '0;
        crc_q   <= 32'h0;
        snap_q  <= 32'h0;
        cmp_q   <= 1'b1;
      end else begin
        phase_q <= phase_d;
        err_q   <= err_d;
        type_q  <= type_d;
        len_q   <= len_d;
        left_q  <= left_d;
        cnt_q   <= cnt_d;
        crc_q   <= crc_d;
        snap_q  <= snap_d;
        cmp_q   <= cmp_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (in_fire) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      o_byte_q <= val_d ? in_i.data_byte : 8'h0;
      o_val_q  <= val_d;
      o_type_q <= type_d;
      o_idx_q  <= cnt_old_ext[3:0];
      o_len_q  <= len_d;
      o_done_q <= done_d;
      o_msg_q  <= in_i.end_of_message;
      o_stat_q <= err_d;
      o_cnt_q  <= cnt_new_ext[4:0];
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.value_byte    = o_byte_q;
  assign out_o.value_valid   = o_val_q;
  assign out_o.record_type   = o_type_q;
  assign out_o.record_index  = o_idx_q;
  assign out_o.record_length = o_len_q;
  assign out_o.record_done   = o_done_q;
  assign out_o.message_done  = o_msg_q;
  assign out_o.status        = o_stat_q;
  assign out_o.record_count  = o_cnt_q;

  `TLVCRC_ASSERT(a_cnt_bound, cnt_q <= CntW'(MaxRecords))
  `TLVCRC_ASSERT(a_err_no_value, in_fire && err_q != StOk |=> !out_o.value_valid)
  `TLVCRC_ASSERT(a_eom_clears, in_fire && in_i.end_of_message |=> phase_q == PhType && cnt_q == '0 && err_q == StOk)
  `TLVCRC_ASSERT(a_done_ok, out_o.valid && out_o.record_done |-> out_o.status == StOk)

endmodule

@@ sim/tlv_stream_parser_crc_check_unit_tb.sv @@
// testbench for the tlv stream parser: directed and random messages, scoreboard, stalls
`timescale 1ns / 100ps

module tlv_stream_parser_crc_check_unit_tb;
  import tlvcrc_pkg::*;

  localparam int unsigned MaxRecs      = MaxRecordsDef;
  localparam int          WatchdogLim  = 4000;
  localparam int          MaxReported  = 10;

  typedef struct packed {
    logic [7:0]  value_byte;
    logic        value_valid;
    logic [7:0]  record_type;
    logic [3:0]  record_index;
    logic [15:0] record_length;
    logic        record_done;
    logic        message_done;
    logic [1:0]  status;
    logic [4:0]  record_count;
  } parse_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_data;

  tlvcrc_in_if  in_if ();
  tlvcrc_out_if out_if ();

  tlv_stream_parser_crc_check_unit u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // parser state as predicted
  tlvcrc_phase_e  p_phase;
  tlvcrc_status_e p_err;
  logic [7:0]     p_type;
  logic [15:0]    p_len;
  logic [15:0]    p_left;
  int unsigned    p_records;
  logic [31:0]    p_crc;
  logic [31:0]    p_snap;
  logic           p_cmp_ok;
  logic [7:0]     csum_code;

  parse_result_t exp_results[$];
  logic [7:0]    msg_bytes[$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_request;
  int hold_cnt;
  int words_sent;
  int msgs_sent;
  int results_checked;
  int records_passed;
  int end_status[4];
  int fail_count;
  int quiet_cycles;

  always #4 clk = ~clk;

  function automatic logic [31:0] crc32_byte_update(input logic [31:0] crc_in,
                                                     input logic [7:0] data);
    logic [31:0] r;
    logic        fb;
    r = ~crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r = {1'b0, r[31:1]} ^ (fb ? CrcPoly : 32'h0);
    end
    return ~r;
  endfunction

  function automatic void clear_parse_state();
    p_phase   = PhType;
    p_err     = StOk;
    p_type    = '0;
    p_len     = '0;
    p_left    = '0;
    p_records = 0;
    p_crc     = '0;
    p_snap    = '0;
    p_cmp_ok  = 1'b1;
  endfunction

  // a checksum record must be at least four bytes and match the crc snapshot
  function automatic logic close_record();
    if (p_type == csum_code && (p_len < 16'd4 || !p_cmp_ok)) begin
      p_err = StMismatch;
      return 1'b0;
    end
    p_records++;
    p_phase = PhType;
    return 1'b1;
  endfunction

  function automatic parse_result_t predict_parse(input logic [7:0] b, input logic eom);
    parse_result_t r;
    logic          took_value;
    logic          done;
    int unsigned   idx_before;
    int unsigned   pos;
    logic [7:0]    want;
    took_value = 1'b0;
    done       = 1'b0;
    idx_before = p_records;
    if (p_err == StOk) begin
      case (p_phase)
        PhType: begin
          if (p_records >= MaxRecs) begin
            p_err = StTooMany;
          end else begin
            p_type  = b;
            p_len   = '0;
            p_phase = PhLenHi;
          end
        end
        PhLenHi: begin
          p_len   = {b, 8'h00};
          p_phase = PhLenLo;
        end
        PhLenLo: begin
          p_len    = p_len | {8'h00, b};
          p_left   = p_len;
          p_snap   = p_crc;
          p_cmp_ok = 1'b1;
          if (p_len == 16'd0) done = close_record();
          else p_phase = PhValue;
        end
        default: begin
          pos        = 32'(p_len - p_left);
          took_value = 1'b1;
          if (p_type == csum_code && pos < 4) begin
            want = 8'(p_snap >> (24 - 8 * pos));
            if (want != b) p_cmp_ok = 1'b0;
          end
          p_crc  = crc32_byte_update(p_crc, b);
          p_left = p_left - 16'd1;
          if (p_left == 16'd0) done = close_record();
        end
      endcase
      if (eom && p_err == StOk && p_phase != PhType) p_err = StTruncated;
    end
    r.value_byte    = took_value ? b : 8'h00;
    r.value_valid   = took_value;
    r.record_type   = p_type;
    r.record_index  = 4'(idx_before);
    r.record_length = p_len;
    r.record_done   = done;
    r.message_done  = eom;
    r.status        = p_err;
    r.record_count  = 5'(p_records);
    if (eom) clear_parse_state();
    return r;
  endfunction

  // scoreboard, input prediction and watchdog, all on the rising edge
  always @(posedge clk) begin
    parse_result_t act;
    parse_result_t exp_r;
    if (rst_n) begin
      quiet_cycles++;
      if (out_if.valid && out_if.ready) begin
        quiet_cycles = 0;
        act.value_byte    = out_if.value_byte;
        act.value_valid   = out_if.value_valid;
        act.record_type   = out_if.record_type;
        act.record_index  = out_if.record_index;
        act.record_length = out_if.record_length;
        act.record_done   = out_if.record_done;
        act.message_done  = out_if.message_done;
        act.status        = out_if.status;
        act.record_count  = out_if.record_count;
        results_checked++;
        if (act.record_done === 1'b1) records_passed++;
        if (act.message_done === 1'b1 && !$isunknown(act.status)) end_status[act.status]++;
        if (exp_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReported)
            $display("%0t: result word with nothing expected", $time);
        end else begin
          exp_r = exp_results.pop_front();
          if (act !== exp_r) begin
            fail_count++;
            if (fail_count <= MaxReported) begin
              $display("%0t: exp val %02h/%0b type %02h idx %0d len %04h done %0b/%0b st %0d cnt %0d",
                       $time, exp_r.value_byte, exp_r.value_valid, exp_r.record_type,
                       exp_r.record_index, exp_r.record_length, exp_r.record_done,
                       exp_r.message_done, exp_r.status, exp_r.record_count);
              $display("%0t: got val %02h/%0b type %02h idx %0d len %04h done %0b/%0b st %0d cnt %0d",
                       $time, act.value_byte, act.value_valid, act.record_type,
                       act.record_index, act.record_length, act.record_done,
                       act.message_done, act.status, act.record_count);
            end
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        quiet_cycles = 0;
        exp_results.push_back(predict_parse(in_if.data_byte, in_if.end_of_message));
      end
      if (quiet_cycles >= WatchdogLim) begin
        $display("watchdog: no word moved for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side ready, with random stalls and the occasional long hold-off
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_cnt     = hold_request;
      hold_request = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_word(input logic [7:0] b, input logic eom);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= b;
    in_if.end_of_message <= eom;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++)
      send_word(msg_bytes[i], i == msg_bytes.size() - 1);
    msgs_sent++;
  endtask

  task automatic wait_until_idle();
    in_if.valid <= 1'b0;
    while (exp_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_checksum_type(input logic [7:0] code);
    wait_until_idle();
    cfg_we   <= 1'b1;
    cfg_data <= code;
    @(negedge clk);
    cfg_we    <= 1'b0;
    csum_code = code;
  endtask

  task automatic push_header(input logic [7:0] t, input int len);
    msg_bytes.push_back(t);
    msg_bytes.push_back(8'(len >> 8));
    msg_bytes.push_back(8'(len));
  endtask

  // records with random content; checksum records carry the right crc unless damaged or shorter than four bytes
  task automatic build_wellformed(input int n_rec);
    logic [31:0] crc;
    logic [31:0] snap;
    logic [7:0]  t;
    logic [7:0]  v;
    int          len;
    int          k;
    int          bad_pos;
    msg_bytes.delete();
    crc = '0;
    for (int r = 0; r < n_rec; r++) begin
      if ($urandom_range(99) < 25) begin
        k       = $urandom_range(99);
        len     = (k < 12) ? $urandom_range(3) : 4 + $urandom_range(3);
        bad_pos = (k >= 12 && k < 26) ? $urandom_range(3) : -1;
        snap    = crc;
        push_header(csum_code, len);
        for (int i = 0; i < len; i++) begin
          if (i < 4 && len >= 4) v = 8'(snap >> (24 - 8 * i));
          else v = 8'($urandom_range(255));
          if (i == bad_pos) v = v ^ 8'($urandom_range(255, 1));
          msg_bytes.push_back(v);
          crc = crc32_byte_update(crc, v);
        end
      end else begin
        t = 8'($urandom_range(255));
        if (t == csum_code && $urandom_range(9) != 0) t = ~t;
        k   = $urandom_range(99);
        len = (k < 70) ? $urandom_range(6) : ((k < 96) ? 7 + $urandom_range(17)
                                                        : 25 + $urandom_range(40));
        push_header(t, len);
        for (int i = 0; i < len; i++) begin
          v = 8'($urandom_range(255));
          msg_bytes.push_back(v);
          crc = crc32_byte_update(crc, v);
        end
      end
    end
  endtask

  task automatic build_noise();
    int n;
    msg_bytes.delete();
    n = 1 + $urandom_range(11);
    for (int i = 0; i < n; i++) msg_bytes.push_back(8'($urandom_range(255)));
    if ($urandom_range(3) == 0) msg_bytes[0] = csum_code;
  endtask

  task automatic test_directed_cases();
    logic [31:0] crc;
    // plain record then a matching checksum record (type 0 after reset)
    crc = crc32_byte_update(crc32_byte_update(32'h0, 8'h00), 8'hFF);
    msg_bytes = '{8'h11, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h04};
    for (int i = 0; i < 4; i++) msg_bytes.push_back(8'(crc >> (24 - 8 * i)));
    send_message();
    // lone type byte
    msg_bytes = '{8'hA5};
    send_message();
    // largest length, cut off right after the length
    msg_bytes = '{8'h3C, 8'hFF, 8'hFF};
    send_message();
    // short checksum record, then a byte that must be ignored
    msg_bytes = '{8'h00, 8'h00, 8'h02, 8'hAA, 8'hBB, 8'hCC};
    send_message();
    wait_until_idle();
  endtask

  task automatic test_record_limit();
    write_checksum_type(8'hFF);
    // sixteen empty records end cleanly
    msg_bytes.delete();
    for (int r = 0; r < MaxRecs; r++) push_header(8'(r), 0);
    send_message();
    // one record too many, the rest of the message is dropped
    msg_bytes.delete();
    for (int r = 0; r < MaxRecs; r++) push_header(8'($urandom_range(254)), 0);
    push_header(8'h42, 1);
    msg_bytes.push_back(8'h99);
    send_message();
    wait_until_idle();
  endtask

  task automatic test_backpressure();
    hold_request = 60 + $urandom_range(40);
    for (int m = 0; m < 3; m++) begin
      build_wellformed(2);
      send_message();
    end
    hold_request = 30 + $urandom_range(30);
    build_wellformed(3);
    send_message();
    wait_until_idle();
  endtask

  task automatic test_random_traffic(input int n_words);
    int goal;
    int pick;
    int cut;
    goal = words_sent + n_words;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        build_noise();
      end else begin
        build_wellformed(($urandom_range(99) < 5) ? 15 + $urandom_range(3)
                                                   : 1 + $urandom_range(3));
        if (pick < 28 && msg_bytes.size() > 1) begin
          cut = $urandom_range(msg_bytes.size() - 1, 1);
          while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
        end
      end
      send_message();
    end
    wait_until_idle();
  endtask

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_data             = 8'h00;
    in_if.valid          = 1'b0;
    in_if.data_byte      = 8'h00;
    in_if.end_of_message = 1'b0;
    out_if.ready         = 1'b0;
    snd_idle_pct         = 0;
    rcv_idle_pct         = 0;
    hold_request         = 0;
    hold_cnt             = 0;
    words_sent           = 0;
    msgs_sent            = 0;
    results_checked      = 0;
    records_passed       = 0;
    fail_count           = 0;
    quiet_cycles         = 0;
    foreach (end_status[i]) end_status[i] = 0;
    csum_code            = 8'h00;
    clear_parse_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_record_limit();
    test_backpressure();

    // no idling
    write_checksum_type(8'h00);
    test_random_traffic(240);
    // sender idle
    snd_idle_pct = 56;
    write_checksum_type(8'h80);
    test_random_traffic(240);
    // receiver stalling
    snd_idle_pct = 0;
    rcv_idle_pct = 56;
    write_checksum_type(8'($urandom_range(255)));
    test_random_traffic(240);
    // both sides, lightly
    snd_idle_pct = 11;
    rcv_idle_pct = 11;
    write_checksum_type(8'($urandom_range(255)));
    test_random_traffic(240);

    wait_until_idle();
    fail_count += exp_results.size();
    $display("%0d words in %0d messages, %0d results checked, %0d records passed",
             words_sent, msgs_sent, results_checked, records_passed);
    $display("message ends: ok %0d, too many %0d, truncated %0d, checksum bad %0d",
             end_status[StOk], end_status[StTooMany], end_status[StTruncated],
             end_status[StMismatch]);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
